### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### rtl/bmp_pkg.sv
// Package for the bilinear multivector product: default sizes, fixed port
// field widths, opcodes and the control struct passed to the MAC unit.
// Depends on nothing.
package bmp_pkg;

    localparam int BLADES_DEF     = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int TABLES_DEF     = 2;

    localparam int COEF_IDX_W = 12;
    localparam int COMP_W     = 4;
    localparam int RIDX_W     = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_COMP = 1'b1;

    localparam logic TAB_GEOMETRIC = 1'b0;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

### rtl/bmp_coef_mem.sv
// Coefficient memory: one write port, one read port with registered data.
// Depends on nothing.
module bmp_coef_mem #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic signed [WIDTH-1:0] wdata,
    input  logic [AW-1:0]           raddr,
    output logic signed [WIDTH-1:0] rdata
);

    logic signed [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/bmp_mac.sv
// Shared multiply-accumulate unit: component stores, two registered
// multiplies with floor shifts, accumulator and output saturation.
// Depends on bmp_pkg.
module bmp_mac #(
    parameter int BLADES     = bmp_pkg::BLADES_DEF,
    parameter int DATA_WIDTH = bmp_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = bmp_pkg::COEF_WIDTH_DEF,
    localparam int IDX_W = $clog2(BLADES)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_idx,
    input  logic signed [DATA_WIDTH-1:0] wr_left,
    input  logic signed [DATA_WIDTH-1:0] wr_right,
    input  bmp_pkg::mac_ctl_t            ctl,
    input  logic [IDX_W-1:0]             j,
    input  logic [IDX_W-1:0]             k,
    input  logic signed [COEF_WIDTH-1:0] coef,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] sat_value
);

    localparam int FRAC   = DATA_WIDTH / 2;
    localparam int CFRAC  = COEF_WIDTH - 3;
    localparam int P_W    = 2 * DATA_WIDTH;
    localparam int Q_W    = P_W - FRAC;
    localparam int QC_W   = Q_W + COEF_WIDTH;
    localparam int T_W    = QC_W - CFRAC;
    localparam int ACC_W  = T_W + 3 * IDX_W;

    logic signed [DATA_WIDTH-1:0] left_mem  [BLADES];
    logic signed [DATA_WIDTH-1:0] right_mem [BLADES];

    bmp_pkg::mac_ctl_t ctl1_reg;
    bmp_pkg::mac_ctl_t ctl2_reg;
    bmp_pkg::mac_ctl_t ctl3_reg;
    logic              done_reg;

    logic signed [DATA_WIDTH-1:0] x1_reg;
    logic signed [DATA_WIDTH-1:0] y1_reg;
    logic signed [Q_W-1:0]        q2_reg;
    logic signed [COEF_WIDTH-1:0] c2_reg;
    logic signed [T_W-1:0]        t3_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [ACC_W-1:0]      acc_next;

    logic signed [P_W-1:0]  prod;
    logic signed [QC_W-1:0] qc;
    logic                   fits;

    assign prod = x1_reg * y1_reg;
    assign qc   = q2_reg * c2_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_idx]  <= wr_left;
            right_mem[wr_idx] <= wr_right;
        end
        x1_reg  <= left_mem[j];
        y1_reg  <= right_mem[k];
        q2_reg  <= Q_W'(prod >>> FRAC);
        c2_reg  <= coef;
        t3_reg  <= T_W'(qc >>> CFRAC);
        acc_reg <= acc_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl3_reg.valid)
        begin
            acc_next = ctl3_reg.first ? ACC_W'(t3_reg) : acc_reg + ACC_W'(t3_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            done_reg <= ctl3_reg.valid && ctl3_reg.last;
        end
    end

    assign fits = (&acc_reg[ACC_W-1:DATA_WIDTH-1]) || !(|acc_reg[ACC_W-1:DATA_WIDTH-1]);

    always_comb
    begin
        if (fits)
        begin
            sat_value = acc_reg[DATA_WIDTH-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            sat_value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    assign done = done_reg;

endmodule

### rtl/bmp_seq.sv
// Sequencer: walks rows, then j and k of each row, through the shared MAC;
// waits for a free output slot before each row and for the row to drain.
// Depends on bmp_pkg.
module bmp_seq #(
    parameter int BLADES = bmp_pkg::BLADES_DEF,
    localparam int IDX_W  = $clog2(BLADES),
    localparam int TERM_W = $clog2(BLADES * BLADES * BLADES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              out_free,
    input  logic              row_done,
    output logic              idle,
    output bmp_pkg::mac_ctl_t ctl,
    output logic [IDX_W-1:0]  j,
    output logic [IDX_W-1:0]  k,
    output logic [IDX_W-1:0]  row,
    output logic [TERM_W-1:0] term,
    output logic              last_row
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_RUN,
        S_DRAIN
    } state_t;

    localparam logic [IDX_W-1:0] TOP = IDX_W'(BLADES - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  i_next;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  j_next;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  k_next;
    logic [TERM_W-1:0] term_reg;
    logic [TERM_W-1:0] term_next;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        term_next  = term_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_WAIT;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    term_next  = '0;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                term_next = term_reg + TERM_W'(1);
                if (k_reg == TOP)
                begin
                    k_next = '0;
                    if (j_reg == TOP)
                    begin
                        j_next     = '0;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (row_done)
                begin
                    if (i_reg == TOP)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = S_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            term_reg  <= term_next;
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign ctl.valid = (state_reg == S_RUN);
    assign ctl.first = (j_reg == '0) && (k_reg == '0);
    assign ctl.last  = (j_reg == TOP) && (k_reg == TOP);
    assign j         = j_reg;
    assign k         = k_reg;
    assign row       = i_reg;
    assign term      = term_reg;
    assign last_row  = (i_reg == TOP);

endmodule

### rtl/bilinear_multivector_product.sv
// Bilinear multivector product over BLADES components with one shared MAC.
// Load items and non-final component items are accepted back to back while idle.
// A final component item yields BLADES result rows; each row waits for a free output
// slot, runs one MAC per cycle over all j and k, then drains the MAC pipeline.
// Ready is low from the final component item until the last row drains.
// rst_n clears control state and product_kind; coefficients and components hold until written.
`include "assert_macros.svh"

module bilinear_multivector_product #(
    parameter int BLADES     = bmp_pkg::BLADES_DEF,
    parameter int DATA_WIDTH = bmp_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = bmp_pkg::COEF_WIDTH_DEF,
    parameter int TABLES     = bmp_pkg::TABLES_DEF,
    localparam int CIDX_LSB  = 1,
    localparam int CVAL_LSB  = CIDX_LSB + bmp_pkg::COEF_IDX_W,
    localparam int COMP_LSB  = CVAL_LSB + COEF_WIDTH,
    localparam int LEFT_LSB  = COMP_LSB + bmp_pkg::COMP_W,
    localparam int RIGHT_LSB = LEFT_LSB + DATA_WIDTH,
    localparam int IN_BITS   = RIGHT_LSB + DATA_WIDTH,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = bmp_pkg::RIDX_W + DATA_WIDTH,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // table_id, coef_index, coef_value, component, left_value, right_value
    input  logic [IN_W-1:0]  s_tdata,
    // op
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // result_index, result_value
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data
);

    localparam int IDX_W     = $clog2(BLADES);
    localparam int EXT_W     = (IDX_W > bmp_pkg::COMP_W) ? IDX_W : bmp_pkg::COMP_W;
    localparam int CUBE      = BLADES * BLADES * BLADES;
    localparam int TERM_W    = $clog2(CUBE);
    localparam int MEM_DEPTH = TABLES * CUBE;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int RIDX_W    = bmp_pkg::RIDX_W;

    logic                            in_accept;
    logic                            in_table;
    logic [bmp_pkg::COEF_IDX_W-1:0]  in_cidx;
    logic signed [COEF_WIDTH-1:0]    in_cval;
    logic [bmp_pkg::COMP_W-1:0]      in_comp;
    logic [EXT_W-1:0]                comp_ext;
    logic [IDX_W-1:0]                comp_idx;
    logic                            comp_ok;
    logic                            comp_wr;
    logic                            start;
    logic                            load_wr;
    logic [MEM_AW-1:0]               load_addr;
    logic [MEM_AW-1:0]               rd_addr;
    logic signed [COEF_WIDTH-1:0]    coef;

    logic                            product_kind_reg;
    logic                            tab_sel;

    logic                            seq_idle;
    bmp_pkg::mac_ctl_t               mac_ctl;
    logic [IDX_W-1:0]                seq_j;
    logic [IDX_W-1:0]                seq_k;
    logic [IDX_W-1:0]                seq_row;
    logic [TERM_W-1:0]               seq_term;
    logic                            seq_last_row;
    logic                            out_free;
    logic                            mac_done;
    logic signed [DATA_WIDTH-1:0]    mac_value;

    logic                            m_valid_reg;
    logic                            m_last_reg;
    logic [RIDX_W-1:0]               m_index_reg;
    logic [DATA_WIDTH-1:0]           m_value_reg;

    assign in_accept = s_tvalid && s_tready;
    assign in_table  = s_tdata[0];
    assign in_cidx   = s_tdata[CVAL_LSB-1:CIDX_LSB];
    assign in_cval   = s_tdata[COMP_LSB-1:CVAL_LSB];
    assign in_comp   = s_tdata[LEFT_LSB-1:COMP_LSB];
    assign comp_ext  = EXT_W'(in_comp);
    assign comp_idx  = comp_ext[IDX_W-1:0];
    assign comp_ok   = 32'(in_comp) < BLADES;

    assign comp_wr = in_accept && (s_tuser == bmp_pkg::OP_COMP) && comp_ok;
    assign start   = comp_wr && (comp_idx == IDX_W'(BLADES - 1));
    assign load_wr = in_accept && (s_tuser == bmp_pkg::OP_LOAD)
                     && (32'(in_table) < TABLES) && (32'(in_cidx) < CUBE);

    assign load_addr = in_table ? MEM_AW'(CUBE + 32'(in_cidx)) : MEM_AW'(in_cidx);

    // Out-of-range kind falls back to the geometric table.
    assign tab_sel = (32'(product_kind_reg) < TABLES) ? product_kind_reg
                                                      : bmp_pkg::TAB_GEOMETRIC;
    assign rd_addr = tab_sel ? MEM_AW'(CUBE + 32'(seq_term)) : MEM_AW'(seq_term);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = seq_idle;

    bmp_coef_mem #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (COEF_WIDTH)
    ) u_coef_mem (
        .clk   (clk),
        .we    (load_wr),
        .waddr (load_addr),
        .wdata (in_cval),
        .raddr (rd_addr),
        .rdata (coef)
    );

    bmp_seq #(
        .BLADES (BLADES)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .row_done (mac_done),
        .idle     (seq_idle),
        .ctl      (mac_ctl),
        .j        (seq_j),
        .k        (seq_k),
        .row      (seq_row),
        .term     (seq_term),
        .last_row (seq_last_row)
    );

    bmp_mac #(
        .BLADES     (BLADES),
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (comp_wr),
        .wr_idx    (comp_idx),
        .wr_left   (s_tdata[RIGHT_LSB-1:LEFT_LSB]),
        .wr_right  (s_tdata[IN_BITS-1:RIGHT_LSB]),
        .ctl       (mac_ctl),
        .j         (seq_j),
        .k         (seq_k),
        .coef      (coef),
        .done      (mac_done),
        .sat_value (mac_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_kind_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                product_kind_reg <= cfg_wr_data;
            end
            if (mac_done)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_done)
        begin
            m_index_reg <= RIDX_W'(seq_row);
            m_value_reg <= mac_value;
            m_last_reg  <= seq_last_row;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_value_reg, m_index_reg});
    assign m_tlast  = m_last_reg;

    `ASSERT_IMPLIES(a_busy_on_done, clk, rst_n, mac_done, !s_tready, "row finished while ready")
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, mac_done, !m_valid_reg, "row result overran output")
    `ASSERT_IMPLIES(a_valid_source, clk, rst_n, $rose(m_valid_reg), $past(mac_done), "output valid without row")

endmodule

### sim/bmp_checker.sv
`timescale 1ns / 1ps
// Checker for bilinear_multivector_product: predicts each product from the loaded
// tables, the gathered components and product_kind, then compares every result item.
// Depends on bmp_pkg for field widths and opcodes.
module bmp_checker
    import bmp_pkg::*;
#(
    parameter int IN_W  = 104,
    parameter int OUT_W = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    // table_id, coef_index, coef_value, component, left_value, right_value
    input  logic [IN_W-1:0]  s_tdata,
    // op
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    // result_index, result_value
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             m_tlast,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    output int               fail_count,
    output int               pending,
    output int               results_checked
);

    localparam int NB        = BLADES_DEF;
    localparam int DW        = DATA_WIDTH_DEF;
    localparam int CW        = COEF_WIDTH_DEF;
    localparam int DATA_FRAC = DW / 2;
    localparam int COEF_FRAC = CW - 3;
    localparam int PLANE     = NB * NB;
    localparam int CUBE      = NB * PLANE;
    localparam int CIDX_LSB  = 1;
    localparam int CVAL_LSB  = CIDX_LSB + COEF_IDX_W;
    localparam int COMP_LSB  = CVAL_LSB + CW;
    localparam int LEFT_LSB  = COMP_LSB + COMP_W;
    localparam int RIGHT_LSB = LEFT_LSB + DW;
    localparam longint SAT_HI = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic [RIDX_W-1:0] index;
        logic [DW-1:0]     value;
        logic              last;
    } blade_result_t;

    logic signed [CW-1:0] coef_mem [TABLES_DEF * CUBE];
    logic signed [DW-1:0] left_mem [NB];
    logic signed [DW-1:0] right_mem [NB];
    logic                 product_kind = 1'b0;
    blade_result_t        expected_q [$];
    blade_result_t        want;
    logic [COMP_W-1:0]    comp;
    logic [RIDX_W-1:0]    got_index;
    logic [DW-1:0]        got_value;
    int                   coef_slot;

    function automatic void queue_product();
        longint        acc;
        longint        term;
        int            base;
        blade_result_t r;
        base = int'(product_kind) * CUBE;
        for (int i = 0; i < NB; i++)
        begin
            acc = 0;
            for (int j = 0; j < NB; j++)
            begin
                for (int k = 0; k < NB; k++)
                begin
                    term = (longint'(left_mem[j]) * longint'(right_mem[k])) >>> DATA_FRAC;
                    acc += (term * longint'(coef_mem[base + i * PLANE + j * NB + k]))
                           >>> COEF_FRAC;
                end
            end
            if (acc > SAT_HI)
                acc = SAT_HI;
            if (acc < SAT_LO)
                acc = SAT_LO;
            r.index = RIDX_W'(i);
            r.value = acc[DW-1:0];
            r.last = (i == NB - 1);
            expected_q.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            product_kind = 1'b0;
            pending = 0;
            fail_count = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg_wr_en === 1'b1)
                product_kind = cfg_wr_data;

            if (s_tvalid === 1'b1 && s_tready === 1'b1)
            begin
                if (s_tuser == OP_LOAD)
                begin
                    coef_slot = int'(s_tdata[0]) * CUBE + int'(s_tdata[CIDX_LSB +: COEF_IDX_W]);
                    coef_mem[coef_slot] = s_tdata[CVAL_LSB +: CW];
                end
                else
                begin
                    comp = s_tdata[COMP_LSB +: COMP_W];
                    left_mem[comp] = s_tdata[LEFT_LSB +: DW];
                    right_mem[comp] = s_tdata[RIGHT_LSB +: DW];
                    if (comp == COMP_W'(NB - 1))
                        queue_product();
                end
            end

            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                results_checked++;
                got_index = m_tdata[RIDX_W-1:0];
                got_value = m_tdata[RIDX_W +: DW];
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result item, index %0d value %h last %b",
                             $time, got_index, got_value, m_tlast);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got_index !== want.index)
                    begin
                        fail_count++;
                        $display("%0t: result_index expected %0d, got %0d",
                                 $time, want.index, got_index);
                    end
                    if (got_value !== want.value)
                    begin
                        fail_count++;
                        $display("%0t: result_value of blade %0d expected %h, got %h",
                                 $time, want.index, want.value, got_value);
                    end
                    if (m_tlast !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: last of blade %0d expected %b, got %b",
                                 $time, want.index, want.last, m_tlast);
                    end
                end
            end

            pending = expected_q.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for bilinear_multivector_product: fills both coefficient tables,
// then drives directed and random component vectors with random idling on both sides.
// Depends on bmp_pkg, the block and bmp_checker, which predicts and compares.
module tb_top;
    import bmp_pkg::*;

    localparam int NB      = BLADES_DEF;
    localparam int DW      = DATA_WIDTH_DEF;
    localparam int CW      = COEF_WIDTH_DEF;
    localparam int CUBE    = NB * NB * NB;
    localparam int IN_BITS = 1 + COEF_IDX_W + CW + COMP_W + 2 * DW;
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_PAD  = IN_W - IN_BITS;
    localparam int OUT_W   = ((RIDX_W + DW + 7) / 8) * 8;

    localparam int RANDOM_ITEMS  = 410;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 300;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             cfg_wr_en = 1'b0;
    logic             cfg_wr_data = 1'b0;

    int fail_count;
    int pending;
    int results_checked;
    int items_sent = 0;
    int loads_sent = 0;
    int pairs_sent = 0;
    int products_sent = 0;
    int stall_cycles = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    bilinear_multivector_product u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    bmp_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (s_tvalid === 1'b1 && s_tready === 1'b1)
            || (m_tvalid === 1'b1 && m_tready === 1'b1) || cfg_wr_en === 1'b1)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [IN_W-1:0] pack_item(
        input logic                  tab,
        input logic [COEF_IDX_W-1:0] idx,
        input logic [CW-1:0]         cval,
        input logic [COMP_W-1:0]     comp,
        input logic [DW-1:0]         lval,
        input logic [DW-1:0]         rval
    );
        pack_item = {{IN_PAD{1'b0}}, rval, lval, comp, cval, idx, tab};
    endfunction

    function automatic logic [CW-1:0] coef_draw();
        case ($urandom_range(0, 9))
            0: coef_draw = ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
            1, 2: coef_draw = CW'($urandom);
            3, 4, 5: coef_draw = ($urandom_range(0, 1) != 0) ? 16'h2000 : 16'he000;
            default: coef_draw = '0;
        endcase
    endfunction

    function automatic logic [DW-1:0] value_draw();
        case ($urandom_range(0, 9))
            0: value_draw = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            1, 2: value_draw = DW'($urandom);
            default: value_draw = DW'($urandom_range(0, 32'h7_ffff)) - 32'h4_0000;
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [IN_W-1:0] data);
        int gap;
        gap = tx_quiet ? 0 : int'($urandom_range(0, 19));
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_load(input logic tab, input logic [COEF_IDX_W-1:0] idx,
                             input logic [CW-1:0] cval);
        send_item(OP_LOAD, pack_item(tab, idx, cval, COMP_W'($urandom), DW'($urandom),
                                     DW'($urandom)));
        loads_sent++;
    endtask

    task automatic send_pair(input logic [COMP_W-1:0] comp, input logic [DW-1:0] lval,
                             input logic [DW-1:0] rval);
        send_item(OP_COMP, pack_item(1'($urandom), COEF_IDX_W'($urandom), CW'($urandom),
                                     comp, lval, rval));
        pairs_sent++;
        if (comp == COMP_W'(NB - 1))
            products_sent++;
    endtask

    // Drop valid, let the block drain, then write product_kind.
    task automatic write_kind(input logic kind_value);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= kind_value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_sequence();
        logic [COMP_W-1:0] order [NB-1];
        logic [COMP_W-1:0] swap;
        int                pick;
        case ($urandom_range(0, 9))
            0, 1:
                repeat ($urandom_range(1, 8))
                    send_load(1'($urandom), COEF_IDX_W'($urandom), coef_draw());
            2, 3:
            begin
                repeat ($urandom_range(0, 5))
                    send_pair(COMP_W'($urandom_range(0, NB - 2)), value_draw(), value_draw());
                send_pair(COMP_W'(NB - 1), value_draw(), value_draw());
            end
            default:
            begin
                for (int i = 0; i < NB - 1; i++)
                    order[i] = COMP_W'(i);
                for (int i = NB - 2; i > 0; i--)
                begin
                    pick = int'($urandom_range(0, i));
                    swap = order[i];
                    order[i] = order[pick];
                    order[pick] = swap;
                end
                foreach (order[i])
                    send_pair(order[i], value_draw(), value_draw());
                send_pair(COMP_W'(NB - 1), value_draw(), value_draw());
            end
        endcase
    endtask

    initial
    begin : drain_results
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 31) == 0)
                rx_quiet = !rx_quiet;
            hold = rx_quiet ? 0 : int'($urandom_range(0, 19));
            if (hold != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
        end
    end

    initial
    begin : stimulus
        logic [DW-1:0] corner_vals [6];
        int            random_start;
        corner_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                        32'hffff_ffff, 32'h0001_0000, 32'hffff_0000};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_kind(TAB_GEOMETRIC);

        // Fill every entry of both tables before any product reads them.
        for (int t = 0; t < TABLES_DEF; t++)
        begin
            for (int n = 0; n < CUBE; n++)
            begin
                if (n % 512 == 0)
                    tx_quiet = ($urandom_range(0, 2) != 0);
                send_load(1'(t), COEF_IDX_W'(n),
                          ($urandom_range(0, 15) == 0) ? CW'($urandom) : '0);
            end
        end

        tx_quiet = 1'b0;
        send_load(1'b0, '0, 16'h8000);
        send_load(1'b1, '1, 16'h7fff);
        send_load(1'b0, '1, 16'h2000);
        send_load(1'b1, '0, 16'h0001);
        for (int c = 0; c < NB; c++)
            send_pair(COMP_W'(c), (c < 6) ? corner_vals[c] : value_draw(),
                      (c < 6) ? corner_vals[5 - c] : value_draw());
        write_kind(1'b1);
        send_pair(COMP_W'(NB - 1), 32'h0001_0000, 32'h0002_0000);
        write_kind(TAB_GEOMETRIC);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                write_kind(1'($urandom_range(0, 1)));
            tx_quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3))
                run_sequence();
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d coefficient loads and %0d component pairs, %0d products",
                 loads_sent, pairs_sent, products_sent);
        $display("over both tables; %0d result items compared, %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
